>>> rtl/core/jsv_pkg.sv
// jsv_pkg: shared types and codes for the JSON structure validator.
// Token kinds, expected-role masks, stack marks and result codes.
// No dependencies.
package jsv_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam int TOKW = 4;
    localparam int EXPW = 10;
    localparam int DEPW = 7;
    localparam int RESW = 2;

    typedef logic [TOKW-1:0] t_token;
    typedef logic [EXPW-1:0] t_expect;
    typedef logic [1:0]      t_mark;
    typedef logic [RESW-1:0] t_result;

    localparam t_token TOK_END       = 4'd0;
    localparam t_token TOK_OBJ_OPEN  = 4'd1;
    localparam t_token TOK_OBJ_CLOSE = 4'd2;
    localparam t_token TOK_ARR_OPEN  = 4'd3;
    localparam t_token TOK_ARR_CLOSE = 4'd4;
    localparam t_token TOK_COLON     = 4'd5;
    localparam t_token TOK_COMMA     = 4'd6;
    localparam t_token TOK_STRING    = 4'd7;
    localparam t_token TOK_BOOLEAN   = 4'd8;
    localparam t_token TOK_NUMBER    = 4'd9;
    localparam t_token TOK_NULL      = 4'd10;
    localparam t_token TOK_INVALID   = 4'd11;

    localparam t_expect EXP_DOC_END   = 10'h001;
    localparam t_expect EXP_OBJ_BEGIN = 10'h002;
    localparam t_expect EXP_OBJ_END   = 10'h004;
    localparam t_expect EXP_OBJ_KEY   = 10'h008;
    localparam t_expect EXP_OBJ_VALUE = 10'h010;
    localparam t_expect EXP_ARR_BEGIN = 10'h020;
    localparam t_expect EXP_ARR_END   = 10'h040;
    localparam t_expect EXP_ARR_VALUE = 10'h080;
    localparam t_expect EXP_COLON     = 10'h100;
    localparam t_expect EXP_COMMA     = 10'h200;
    localparam t_expect EXP_INIT      = EXP_OBJ_BEGIN | EXP_ARR_BEGIN;

    localparam t_mark MK_NONE   = 2'd0;
    localparam t_mark MK_OBJECT = 2'd1;
    localparam t_mark MK_ARRAY  = 2'd2;
    localparam t_mark MK_KEY    = 2'd3;

    localparam t_result RES_ACCEPT   = 2'd0;
    localparam t_result RES_ERROR    = 2'd1;
    localparam t_result RES_COMPLETE = 2'd2;

endpackage

>>> rtl/core/json_structure_validator_core.sv
// json_structure_validator_core: pushdown syntax checker for a JSON token stream.
// Depends on jsv_pkg. Mark stack is an in-module memory.
//
// One token kind per item, one result per item. A new item is taken every cycle
// while the result register is empty or being drained; its result shows in the cycle
// after acceptance. The whole check and the stack update settle in the accepting
// cycle: the top two marks come from registered memory reads addressed by the next
// depth, with a bypass register for a mark just pushed. The stack needs no clearing
// pass after reset. Errors stay latched until an item arrives with doc_start set.
module json_structure_validator_core
    import jsv_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] content_ok, [1] doc_start, [7:2] zero
    input  logic [3:0]  i_s_tuser,   // [3:0] token_kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [6:0] nesting_depth, [16:7] expected_set, [23:17] zero
    output logic [1:0]  o_m_tuser    // [1:0] result_code
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_mark          mem [STACK_DEPTH];

    logic [CW-1:0]  r_count, n_count;
    t_expect        r_flags, n_flags;
    logic           r_err,   n_err;
    t_mark          r_rd_top, r_rd_below, r_byp_mark;
    logic           r_byp;
    logic           r_out_valid;
    t_result        r_out_code, n_code;
    logic [DEPW-1:0] r_out_depth;
    t_expect        r_out_flags;

    logic           accept;
    t_token         tok;
    logic           ok, doc;
    t_expect        e_flags;
    logic [CW-1:0]  e_count;
    logic           e_err;
    t_mark          top, below;
    logic           full;
    logic           good, push;
    t_mark          push_mark;
    logic           close_req;
    t_mark          close_kind;
    logic [CW-1:0]  idx1, idx2;

    assign accept = i_s_tvalid && o_s_tready;
    assign tok    = i_s_tuser;
    assign ok     = i_s_tdata[0];
    assign doc    = i_s_tdata[1];

    assign e_flags = doc ? EXP_INIT : r_flags;
    assign e_count = doc ? '0 : r_count;
    assign e_err   = doc ? 1'b0 : r_err;
    assign full    = (e_count == CW'(STACK_DEPTH));
    assign top     = (e_count == '0) ? MK_NONE : (r_byp ? r_byp_mark : r_rd_top);
    assign below   = (e_count < CW'(2)) ? MK_NONE : r_rd_below;

    always_comb begin
        good       = 1'b0;
        push       = 1'b0;
        push_mark  = MK_NONE;
        close_req  = 1'b0;
        close_kind = MK_NONE;
        n_code     = RES_ACCEPT;
        n_flags    = e_flags;
        n_count    = e_count;
        case (tok)
            TOK_END: begin
                if (|(e_flags & EXP_DOC_END) && e_count == CW'(1)) begin
                    n_count = '0;
                    n_flags = '0;
                    n_code  = RES_COMPLETE;
                    good    = 1'b1;
                end
            end
            TOK_OBJ_OPEN: begin
                if (|(e_flags & EXP_OBJ_BEGIN) && !full) begin
                    push      = 1'b1;
                    push_mark = MK_OBJECT;
                    n_flags   = EXP_OBJ_KEY | EXP_OBJ_BEGIN | EXP_OBJ_END;
                    good      = 1'b1;
                end
            end
            TOK_OBJ_CLOSE: begin
                close_req  = |(e_flags & EXP_OBJ_END);
                close_kind = MK_OBJECT;
            end
            TOK_ARR_OPEN: begin
                if (|(e_flags & EXP_ARR_BEGIN) && !full) begin
                    push      = 1'b1;
                    push_mark = MK_ARRAY;
                    n_flags   = EXP_ARR_VALUE | EXP_OBJ_BEGIN | EXP_ARR_BEGIN | EXP_ARR_END;
                    good      = 1'b1;
                end
            end
            TOK_ARR_CLOSE: begin
                close_req  = |(e_flags & EXP_ARR_END);
                close_kind = MK_ARRAY;
            end
            TOK_COLON: begin
                if (|(e_flags & EXP_COLON)) begin
                    n_flags = EXP_OBJ_BEGIN | EXP_ARR_BEGIN | EXP_OBJ_VALUE;
                    good    = 1'b1;
                end
            end
            TOK_COMMA: begin
                if (|(e_flags & EXP_COMMA)) begin
                    if (|(e_flags & EXP_OBJ_END)) begin
                        n_flags = EXP_OBJ_KEY;
                    end else if (|(e_flags & EXP_ARR_END)) begin
                        n_flags = EXP_OBJ_BEGIN | EXP_ARR_BEGIN | EXP_ARR_VALUE;
                    end
                    good = 1'b1;
                end
            end
            TOK_STRING, TOK_BOOLEAN, TOK_NUMBER, TOK_NULL: begin
                if (tok == TOK_STRING && |(e_flags & EXP_OBJ_KEY)) begin
                    if (ok && !full) begin
                        push      = 1'b1;
                        push_mark = MK_KEY;
                        n_flags   = EXP_COLON;
                        good      = 1'b1;
                    end
                end else if (|(e_flags & EXP_OBJ_VALUE)) begin
                    if (e_count >= CW'(2) && top == MK_KEY && ok) begin
                        n_count = e_count - CW'(1);
                        n_flags = EXP_COMMA | EXP_OBJ_END;
                        good    = 1'b1;
                    end
                end else if (|(e_flags & EXP_ARR_VALUE)) begin
                    if (top == MK_ARRAY && ok) begin
                        n_flags = EXP_COMMA | EXP_ARR_END;
                        good    = 1'b1;
                    end
                end
            end
            default: begin
                good = 1'b0;
            end
        endcase

        if (close_req && top == close_kind) begin
            if (e_count == CW'(1)) begin
                n_flags = EXP_DOC_END;
                good    = 1'b1;
            end else if (below == MK_KEY) begin
                if (e_count >= CW'(3)) begin
                    n_count = e_count - CW'(2);
                    n_flags = EXP_COMMA | EXP_OBJ_END;
                    good    = 1'b1;
                end
            end else if (below == MK_ARRAY) begin
                n_count = e_count - CW'(1);
                n_flags = EXP_COMMA | EXP_ARR_END;
                good    = 1'b1;
            end
        end

        if (push && good) begin
            n_count = e_count + CW'(1);
        end

        n_err = e_err;
        if (e_err || !good) begin
            n_flags = e_flags;
            n_count = e_count;
            n_err   = 1'b1;
            n_code  = RES_ERROR;
            push    = 1'b0;
        end
    end

    assign idx1 = n_count - CW'(1);
    assign idx2 = n_count - CW'(2);

    // stack memory; top two marks read at the next depth
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (push) begin
                mem[e_count[AW-1:0]] <= push_mark;
            end
            r_rd_top   <= mem[idx1[AW-1:0]];
            r_rd_below <= mem[idx2[AW-1:0]];
            r_byp_mark <= push_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_flags     <= EXP_INIT;
            r_err       <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_flags <= n_flags;
                r_err   <= n_err;
                r_byp   <= push;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_code  <= n_code;
            r_out_depth <= DEPW'(n_count);
            r_out_flags <= n_flags;
        end
    end

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_code;
    assign o_m_tdata  = {7'd0, r_out_flags, r_out_depth};

endmodule

>>> rtl/core/jsv_core_checker.sv
// jsv_core_checker: port-level assertions for json_structure_validator_core.
// Depends on jsv_pkg; bound to json_structure_validator_core below.
module jsv_core_checker
    import jsv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic [3:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("not ready with empty result register");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted item gave no result");

    a_complete_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == RES_COMPLETE |-> o_m_tdata[16:0] == 17'd0)
        else $error("document complete with nonzero depth or expectations");

    a_fresh_object: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[1] && i_s_tuser == TOK_OBJ_OPEN
        |=> o_m_tuser == RES_ACCEPT && o_m_tdata[6:0] == 7'd1)
        else $error("object open after restart not accepted at depth one");

endmodule

bind json_structure_validator_core jsv_core_checker u_jsv_core_checker (.*);
